[rtl/core/bea_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the extent allocator.
package bea_pkg;

    localparam int NUM_BLOCKS    = 4096;
    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

    localparam int WORD_IDX_W = $clog2(MAP_WORDS);
    localparam int BIT_IDX_W  = $clog2(MAP_WORD_BITS);
    localparam int BLK_W      = 12;
    localparam int LIMIT_W    = 13;
    localparam int LEN_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_LEN   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                scan_init;
        logic                scan_step;
        logic                scan_hit;
        logic                walk_init;
        logic                rd_walk;
        logic                chk;
        logic                wr_en;
        logic                wr_set;
        logic                publish;
        logic [STATUS_W-1:0] pub_status;
    } bea_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic op_free;
        logic range_ok;
        logic hit;
        logic scan_last;
        logic walk_last;
        logic chk_ok;
        logic out_full;
    } bea_stat_t;

endpackage

[rtl/core/bea_dp.sv]
// Datapath of the extent allocator: configuration, bitmap memory, scan and update logic.
module bea_dp
    import bea_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  op,
    input  logic [BLK_W-1:0]      start_block,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [STATUS_W-1:0]   status,
    output logic [BLK_W-1:0]      extent_start,
    input  bea_cmd_t              cmd,
    output bea_stat_t             stat
);

    logic [BLK_W-1:0]      search_start_reg;
    logic [LIMIT_W-1:0]    block_limit_reg;
    logic [LEN_W-1:0]      extent_len_reg;

    logic                  req_op_reg;
    logic [BLK_W-1:0]      ext_start_reg;
    logic [WORD_IDX_W-1:0] scan_w_reg;
    logic [LEN_W-1:0]      carry_reg;
    logic [WORD_IDX_W-1:0] walk_w_reg;
    logic                  ok_reg;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [BLK_W-1:0]      extent_start_reg;

    logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0]     map_vld_reg;
    logic [MAP_WORD_BITS-1:0] rd_data_reg;
    logic                     rd_vld_reg;

    logic [LIMIT_W-1:0]       eff_limit;
    logic [LEN_W-1:0]         eff_len;
    logic [WORD_IDX_W-1:0]    ss_word;
    logic [WORD_IDX_W-1:0]    last_w;
    logic [MAP_WORD_BITS-1:0] word;
    logic                     rd_en;
    logic [WORD_IDX_W-1:0]    rd_addr;

    logic [MAP_WORD_BITS-1:0] used_e;
    logic [MAP_WORD_BITS-1:0] top_mask;
    logic [MAP_WORD_BITS-1:0] hit_ok;
    logic [BIT_IDX_W-1:0]     hit_b;
    logic [LIMIT_W-1:0]       found_start;
    logic [LEN_W-1:0]         carry_next;
    logic [BIT_IDX_W:0]       top_free;
    logic [LEN_W:0]           carry_sum;

    logic [LIMIT_W-1:0]       ext_end;
    logic [WORD_IDX_W-1:0]    end_w;
    logic [MAP_WORD_BITS-1:0] walk_mask;
    logic [MAP_WORD_BITS-1:0] wr_data;

    assign eff_limit = (block_limit_reg > LIMIT_W'(NUM_BLOCKS)) ? LIMIT_W'(NUM_BLOCKS)
                                                                : block_limit_reg;
    assign eff_len   = (extent_len_reg == '0) ? LEN_W'(1) : extent_len_reg;
    assign ss_word   = search_start_reg[BLK_W-1:BIT_IDX_W];

    always_comb
    begin
        logic [LIMIT_W-1:0] lim_m1;
        lim_m1 = eff_limit - LIMIT_W'(1);
        last_w = (eff_limit == '0) ? '0 : lim_m1[BLK_W-1:BIT_IDX_W];
    end

    // A row that was never written since reset reads as all free.
    assign word = rd_vld_reg ? rd_data_reg : '0;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_start_reg <= '0;
            block_limit_reg  <= LIMIT_W'(NUM_BLOCKS);
            extent_len_reg   <= LEN_W'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SEARCH_START: search_start_reg <= cfg_wdata[BLK_W-1:0];
                CFG_BLOCK_LIMIT:  block_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                CFG_EXTENT_LEN:   extent_len_reg   <= cfg_wdata[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Bitmap memory, one port read and one port written per cycle.
    assign rd_en   = cmd.scan_init | cmd.scan_step | cmd.rd_walk;
    assign rd_addr = cmd.scan_init ? ss_word :
                     cmd.scan_step ? scan_w_reg + WORD_IDX_W'(1) : walk_w_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            map_mem[walk_w_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                map_vld_reg[walk_w_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= map_vld_reg[rd_addr];
            end
        end
    end

    // Scan of one word: blocks below the search start or at or above the limit count as used.
    // An extent that ends at bit b fits when the top eff_len bits of the word shifted so
    // that b lands on the MSB are free, and any part reaching into earlier words is
    // covered by the free run carried in from them.
    always_comb
    begin
        logic [LIMIT_W-1:0]       idx;
        logic [MAP_WORD_BITS-1:0] win;
        logic [LEN_W+1:0]         need_sum;
        logic [LEN_W+1:0]         pos;
        for (int k = 0; k < MAP_WORD_BITS; k++)
        begin
            idx = LIMIT_W'({scan_w_reg, BIT_IDX_W'(k)});
            used_e[k] = word[k] | (idx < LIMIT_W'(search_start_reg)) | (idx >= eff_limit);
            top_mask[k] = ((LEN_W + 2)'(k) + (LEN_W + 2)'(eff_len))
                          >= (LEN_W + 2)'(MAP_WORD_BITS);
        end
        for (int b = 0; b < MAP_WORD_BITS; b++)
        begin
            win      = used_e << (MAP_WORD_BITS - 1 - b);
            pos      = (LEN_W + 2)'(b + 1);
            need_sum = (LEN_W + 2)'(carry_reg) + pos;
            hit_ok[b] = ((win & top_mask) == '0)
                        && (((LEN_W + 2)'(eff_len) <= pos)
                            || (need_sum >= (LEN_W + 2)'(eff_len)));
        end
        hit_b = '0;
        for (int b = MAP_WORD_BITS - 1; b >= 0; b--)
        begin
            if (hit_ok[b])
            begin
                hit_b = BIT_IDX_W'(b);
            end
        end
        found_start = LIMIT_W'({scan_w_reg, hit_b}) + LIMIT_W'(1) - LIMIT_W'(eff_len);

        // Free run at the top of the word, carried into the next word.
        top_free = (BIT_IDX_W + 1)'(MAP_WORD_BITS);
        for (int k = 0; k < MAP_WORD_BITS; k++)
        begin
            if (used_e[k])
            begin
                top_free = (BIT_IDX_W + 1)'(MAP_WORD_BITS - 1 - k);
            end
        end
        carry_sum = (LEN_W + 1)'(carry_reg) + (LEN_W + 1)'(MAP_WORD_BITS);
        if (used_e != '0)
        begin
            carry_next = LEN_W'(top_free);
        end
        else if (carry_sum[LEN_W])
        begin
            carry_next = '1;
        end
        else
        begin
            carry_next = carry_sum[LEN_W-1:0];
        end
    end

    // Extent window for the check, mark and clear sweeps.
    assign ext_end = LIMIT_W'(ext_start_reg) + LIMIT_W'(eff_len) - LIMIT_W'(1);
    assign end_w   = ext_end[BLK_W-1:BIT_IDX_W];

    always_comb
    begin
        logic [LIMIT_W-1:0] idx;
        for (int k = 0; k < MAP_WORD_BITS; k++)
        begin
            idx = LIMIT_W'({walk_w_reg, BIT_IDX_W'(k)});
            walk_mask[k] = (idx >= LIMIT_W'(ext_start_reg)) && (idx <= ext_end);
        end
    end

    assign wr_data = cmd.wr_set ? (word | walk_mask) : (word & ~walk_mask);

    // Request and walk registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_op_reg    <= op;
            ext_start_reg <= (op == OP_FREE) ? start_block : '0;
        end
        else if (cmd.scan_hit)
        begin
            ext_start_reg <= found_start[BLK_W-1:0];
        end
        if (cmd.scan_init)
        begin
            scan_w_reg <= ss_word;
            carry_reg  <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_w_reg <= scan_w_reg + WORD_IDX_W'(1);
            carry_reg  <= carry_next;
        end
        if (cmd.walk_init)
        begin
            walk_w_reg <= ext_start_reg[BLK_W-1:BIT_IDX_W];
            ok_reg     <= 1'b1;
        end
        else if (cmd.chk)
        begin
            walk_w_reg <= walk_w_reg + WORD_IDX_W'(1);
            ok_reg     <= ok_reg & ((word & walk_mask) == walk_mask);
        end
        else if (cmd.wr_en)
        begin
            walk_w_reg <= walk_w_reg + WORD_IDX_W'(1);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            status_reg       <= cmd.pub_status;
            extent_start_reg <= ext_start_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign extent_start = extent_start_reg;

    assign stat.op_free   = (req_op_reg == OP_FREE);
    assign stat.range_ok  = (LIMIT_W'(ext_start_reg) + LIMIT_W'(eff_len)) <= eff_limit;
    assign stat.hit       = |hit_ok;
    assign stat.scan_last = (scan_w_reg >= last_w);
    assign stat.walk_last = (walk_w_reg == end_w);
    assign stat.chk_ok    = ok_reg;
    assign stat.out_full  = out_valid_reg & out_stall;

endmodule

[rtl/core/bea_ctrl.sv]
// Controller state machine that sequences scan, check, mark and clear sweeps.
module bea_ctrl
    import bea_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  bea_stat_t stat,
    output bea_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_SCAN     = 4'd2;
    localparam logic [3:0] ST_MARK_INI = 4'd3;
    localparam logic [3:0] ST_MARK_RD  = 4'd4;
    localparam logic [3:0] ST_MARK_WR  = 4'd5;
    localparam logic [3:0] ST_CHK_RD   = 4'd6;
    localparam logic [3:0] ST_CHK_EVAL = 4'd7;
    localparam logic [3:0] ST_FREE_DEC = 4'd8;
    localparam logic [3:0] ST_CLR_RD   = 4'd9;
    localparam logic [3:0] ST_CLR_WR   = 4'd10;
    localparam logic [3:0] ST_RESULT   = 4'd11;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [STATUS_W-1:0] res_reg;
    logic [STATUS_W-1:0] res_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!stat.op_free)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
                else if (stat.range_ok)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_CHK_RD;
                end
                else
                begin
                    res_next   = STATUS_BAD_FREE;
                    state_next = ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.scan_hit = 1'b1;
                    state_next   = ST_MARK_INI;
                end
                else if (stat.scan_last)
                begin
                    res_next   = STATUS_NO_SPACE;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_MARK_INI:
            begin
                cmd.walk_init = 1'b1;
                state_next    = ST_MARK_RD;
            end
            ST_MARK_RD:
            begin
                cmd.rd_walk = 1'b1;
                state_next  = ST_MARK_WR;
            end
            ST_MARK_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_set = 1'b1;
                if (stat.walk_last)
                begin
                    res_next   = STATUS_OK;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_MARK_RD;
                end
            end
            ST_CHK_RD:
            begin
                cmd.rd_walk = 1'b1;
                state_next  = ST_CHK_EVAL;
            end
            ST_CHK_EVAL:
            begin
                cmd.chk    = 1'b1;
                state_next = stat.walk_last ? ST_FREE_DEC : ST_CHK_RD;
            end
            ST_FREE_DEC:
            begin
                if (stat.chk_ok)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_CLR_RD;
                end
                else
                begin
                    res_next   = STATUS_BAD_FREE;
                    state_next = ST_RESULT;
                end
            end
            ST_CLR_RD:
            begin
                cmd.rd_walk = 1'b1;
                state_next  = ST_CLR_WR;
            end
            ST_CLR_WR:
            begin
                cmd.wr_en = 1'b1;
                if (stat.walk_last)
                begin
                    res_next   = STATUS_OK;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_CLR_RD;
                end
            end
            ST_RESULT:
            begin
                if (!stat.out_full)
                begin
                    cmd.publish    = 1'b1;
                    cmd.pub_status = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_reg   <= STATUS_OK;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule

[rtl/core/bitmap_extent_allocator_top.sv]
// Top level of the bitmap extent allocator: controller plus datapath.
// Allocate: the scan reads 1 to 128 map words from the search start; when an extent
// is found, each of the 1 to 5 map words it touches is then read and rewritten.
// Free: words of the extent are checked, then cleared; past the limit it is refused before any read.
// One item at a time: the next is taken in the cycle after the result is registered.
// Reset clears the bitmap at once through per-row valid bits and loads the default config.
module bitmap_extent_allocator_top
    import bea_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [BLK_W-1:0]      start_block,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [BLK_W-1:0]      extent_start
);

    // The controller walks each item through its phases: an allocate scans the map one
    // word per cycle from the search start, then read-modify-writes the words that hold
    // the found extent. A free checks every word of the extent first and only clears
    // them when all of its blocks were in use, so a bad free leaves the map untouched.
    bea_cmd_t  cmd;
    bea_stat_t stat;

    // The controller owns sequencing and input flow control.
    bea_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the configuration, the bitmap and the output register, which
    // keeps a finished result while the next item is already being taken in.
    bea_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .op           (op),
        .start_block  (start_block),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .status       (status),
        .extent_start (extent_start),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

[tb/bitmap_extent_allocator_top_test.sv]
// Self-checking testbench for the bitmap extent allocator top level.
`timescale 1ns / 1ps

module bitmap_extent_allocator_top_test;
    import bea_pkg::*;

    // One result item as the block reports it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    start;
    } extent_result_t;

    // An extent the allocator handed out and that has not been given back yet.
    typedef struct {
        int base;
        int len;
    } held_extent_t;

    // Mirror of the allocator: its bitmap and registers, plus the results still awaited.
    class extent_scoreboard;
        bit [NUM_BLOCKS-1:0] used_blocks;
        logic [BLK_W-1:0]    search_start;
        logic [LIMIT_W-1:0]  block_limit;
        logic [LEN_W-1:0]    extent_len;
        extent_result_t      due_results[$];
        int mismatches;
        int n_checked;
        int n_alloc_ok;
        int n_alloc_full;
        int n_free_ok;
        int n_free_bad;

        function new();
            used_blocks  = '0;
            search_start = '0;
            block_limit  = LIMIT_W'(NUM_BLOCKS);
            extent_len   = LEN_W'(16);
            mismatches   = 0;
            n_checked    = 0;
            n_alloc_ok   = 0;
            n_alloc_full = 0;
            n_free_ok    = 0;
            n_free_bad   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SEARCH_START: search_start = data[BLK_W-1:0];
                CFG_BLOCK_LIMIT:  block_limit  = data[LIMIT_W-1:0];
                CFG_EXTENT_LEN:   extent_len   = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int eff_len();
            return (extent_len == 0) ? 1 : int'(extent_len);
        endfunction

        function int eff_limit();
            return (block_limit > NUM_BLOCKS) ? NUM_BLOCKS : int'(block_limit);
        endfunction

        // Applies one accepted item to the mirror and queues the result it must produce.
        function extent_result_t note_item(logic item_op, logic [BLK_W-1:0] blk);
            extent_result_t res;
            int len;
            int lim;
            int run;
            int i;
            int j;
            int b;
            bit ok;
            bit found;
            len = eff_len();
            lim = eff_limit();
            b = int'(blk);
            if (item_op == OP_ALLOC) begin
                // Count free blocks in a row from the search start; the first run that
                // reaches the extent length ends the lowest fitting extent.
                res.status = STATUS_NO_SPACE;
                res.start = '0;
                run = 0;
                found = 1'b0;
                for (i = int'(search_start); !found && i < lim; i++) begin
                    if (used_blocks[i])
                        run = 0;
                    else
                        run++;
                    if (run == len) begin
                        for (j = i - len + 1; j <= i; j++)
                            used_blocks[j] = 1'b1;
                        res.status = STATUS_OK;
                        res.start = BLK_W'(i - len + 1);
                        found = 1'b1;
                    end
                end
                if (found)
                    n_alloc_ok++;
                else
                    n_alloc_full++;
            end
            else begin
                // The whole extent must be in use and below the limit, else nothing changes.
                ok = (b + len <= lim);
                for (j = 0; ok && j < len; j++)
                    if (!used_blocks[b + j])
                        ok = 1'b0;
                if (ok) begin
                    for (j = 0; j < len; j++)
                        used_blocks[b + j] = 1'b0;
                    res.status = STATUS_OK;
                    n_free_ok++;
                end
                else begin
                    res.status = STATUS_BAD_FREE;
                    n_free_bad++;
                end
                res.start = blk;
            end
            due_results.push_back(res);
            return res;
        endfunction

        function void check_result(logic [STATUS_W-1:0] got_status, logic [BLK_W-1:0] got_start);
            extent_result_t exp_res;
            n_checked++;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH %0d: result status %0d start %0d arrived with none due",
                             mismatches, got_status, got_start);
                return;
            end
            exp_res = due_results.pop_front();
            if (exp_res.status !== got_status || exp_res.start !== got_start) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH %0d: expected status %0d start %0d, got status %0d start %0d",
                             mismatches, exp_res.status, exp_res.start, got_status, got_start);
            end
        endfunction
    endclass

    localparam int SETTLE_CYCLES = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    logic                  op;
    logic [BLK_W-1:0]      start_block;
    logic                  out_valid;
    logic                  out_stall;
    logic [STATUS_W-1:0]   status;
    logic [BLK_W-1:0]      extent_start;

    extent_scoreboard sb;
    held_extent_t     held_extents[$];
    logic             idle_on;
    int               stall_left;
    int               n_settings;

    bitmap_extent_allocator_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .start_block  (start_block),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .extent_start (extent_start)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs. The slowest legal run is well under two
    // milliseconds, so this leaves a wide margin.
    initial
    begin
        #20_000_000;
        $display("Timeout: %0d results still due", sb.due_results.size());
        $display("bitmap_extent_allocator_top_test NOT OK");
        $finish;
    end

    // Idling comes in stretches: while idle_on is low neither side starts a new gap or
    // stall, so the block also sees back-to-back traffic.
    initial
    begin
        idle_on = 1'b1;
        forever
        begin
            repeat ($urandom_range(100, 600)) @(posedge clk);
            idle_on <= 1'b0;
            repeat ($urandom_range(50, 300)) @(posedge clk);
            idle_on <= 1'b1;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 94)
            return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    // Result side: check every accepted result item and stall at random. The stall is
    // independent of out_valid, so stalls also land while the block is still working.
    initial
    begin
        out_stall = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(status, extent_start);
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = gap_len() - 1;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Presents one item and holds it until accepted. Called at a clock edge; returns at
    // one. Valid is only lowered for a gap, and then only once in that step.
    task automatic send_item(input logic item_op, input logic [BLK_W-1:0] blk);
        extent_result_t res;
        int gap;
        int len_now;
        int k;
        bit removed;
        op <= item_op;
        start_block <= blk;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        len_now = sb.eff_len();
        res = sb.note_item(item_op, blk);
        // Keep a list of live extents so that later frees can be well formed.
        if (item_op == OP_ALLOC && res.status == STATUS_OK) begin
            held_extents.push_back('{int'(res.start), len_now});
        end
        else if (item_op == OP_FREE && res.status == STATUS_OK) begin
            removed = 1'b0;
            for (k = 0; !removed && k < held_extents.size(); k++)
                if (held_extents[k].base == int'(blk) && held_extents[k].len == len_now) begin
                    held_extents.delete(k);
                    removed = 1'b1;
                end
        end
        gap = 0;
        if (idle_on && $urandom_range(0, 2) == 0)
            gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lets the block drain, then rewrites all three registers while it is idle.
    task automatic reconfigure(input logic [CFG_DATA_W-1:0] ss_data,
                               input logic [CFG_DATA_W-1:0] lim_data,
                               input logic [CFG_DATA_W-1:0] len_data);
        in_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SEARCH_START;
        cfg_wdata <= ss_data;
        @(posedge clk);
        sb.write_reg(CFG_SEARCH_START, ss_data);
        cfg_index <= CFG_BLOCK_LIMIT;
        cfg_wdata <= lim_data;
        @(posedge clk);
        sb.write_reg(CFG_BLOCK_LIMIT, lim_data);
        cfg_index <= CFG_EXTENT_LEN;
        cfg_wdata <= len_data;
        @(posedge clk);
        sb.write_reg(CFG_EXTENT_LEN, len_data);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Random traffic. Most items are allocations or frees of live extents of the current
    // length, so the map fills, fragments and drains. A few frees are off by one block,
    // and a few items are pure noise with a random operation and start.
    task automatic run_random(input int count, input int alloc_pct);
        int n;
        int r;
        int k;
        int cur_len;
        int candidates[$];
        logic item_op;
        logic [BLK_W-1:0] blk;
        for (n = 0; n < count; n++) begin
            cur_len = sb.eff_len();
            candidates.delete();
            foreach (held_extents[m])
                if (held_extents[m].len == cur_len)
                    candidates.push_back(m);
            r = $urandom_range(0, 99);
            blk = $urandom_range(0, 4095);
            item_op = OP_ALLOC;
            if (r < 8) begin
                item_op = ($urandom_range(0, 1) == 1) ? OP_FREE : OP_ALLOC;
            end
            else if (candidates.size() != 0 && $urandom_range(0, 99) >= alloc_pct) begin
                k = candidates[$urandom_range(0, candidates.size() - 1)];
                item_op = OP_FREE;
                blk = held_extents[k].base;
                if (r < 14)
                    blk = ($urandom_range(0, 1) == 1) ? blk + 1'b1 : blk - 1'b1;
            end
            send_item(item_op, blk);
        end
    endtask

    initial
    begin
        int p;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        op = OP_ALLOC;
        start_block = '0;
        n_settings = 1;
        sb = new();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first on the reset settings: two allocations, a good free, a
        // double free, a free running past the limit, then refilling and releasing.
        send_item(OP_ALLOC, 12'd0);
        send_item(OP_ALLOC, 12'd4095);
        send_item(OP_FREE, 12'd0);
        send_item(OP_FREE, 12'd0);
        send_item(OP_FREE, 12'd4095);
        send_item(OP_ALLOC, 12'd0);
        send_item(OP_FREE, 12'd16);
        send_item(OP_FREE, 12'd0);

        // Search start at the top block, a limit above the map size that must saturate,
        // and a zero length that acts as one block: exactly one block fits.
        reconfigure(13'd4095, 13'd8191, 13'd0);
        send_item(OP_ALLOC, 12'd0);
        send_item(OP_ALLOC, 12'd0);
        send_item(OP_FREE, 12'd4095);
        send_item(OP_FREE, 12'd0);

        // Zero limit with the longest length: nothing can be allocated or freed.
        reconfigure(13'd0, 13'd0, 13'd127);
        send_item(OP_ALLOC, 12'd0);
        send_item(OP_FREE, 12'd0);

        // Lengths above 64 are used as given.
        reconfigure(13'd100, 13'd4096, 13'd127);
        send_item(OP_ALLOC, 12'd4095);
        send_item(OP_ALLOC, 12'd0);
        send_item(OP_FREE, 12'd100);
        send_item(OP_FREE, 12'd227);

        // One extent fits right under the limit; the next one must be refused.
        reconfigure(13'd4000, 13'd4096, 13'd64);
        send_item(OP_ALLOC, 12'd0);
        send_item(OP_ALLOC, 12'd0);
        send_item(OP_FREE, 12'd4000);

        // Search start beyond the limit: allocation fails at once.
        reconfigure(13'd3000, 13'd2000, 13'd1);
        send_item(OP_ALLOC, 12'd0);

        // Random part over a range of settings, including a small window that fills up.
        reconfigure(13'd0, 13'd4096, 13'd16);
        run_random(100, 55);
        reconfigure(13'd0, 13'd4096, 13'd64);
        run_random(60, 85);
        reconfigure(13'd37, 13'd1000, 13'd5);
        run_random(80, 80);
        reconfigure(13'd200, 13'd260, 13'd3);
        run_random(80, 70);
        reconfigure(13'd2000, 13'd4096, 13'd33);
        run_random(60, 60);
        // Raw register data with random upper bits, which the narrower registers drop.
        for (p = 0; p < 3; p++) begin
            reconfigure({1'($urandom_range(0, 1)), 12'($urandom_range(0, 1500))},
                        13'($urandom_range(1024, 8191)),
                        13'($urandom_range(0, 8191)));
            run_random(40, 65);
        end
        reconfigure(13'd0, 13'd4096, 13'd16);
        run_random(50, 50);

        in_valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d results over %0d register settings.", sb.n_checked, n_settings);
        $display("Allocations granted %0d, refused %0d; frees done %0d, rejected %0d.",
                 sb.n_alloc_ok, sb.n_alloc_full, sb.n_free_ok, sb.n_free_bad);
        if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
            $display("bitmap_extent_allocator_top_test OK");
        end
        else begin
            $display("%0d mismatches, %0d results never arrived",
                     sb.mismatches, sb.due_results.size());
            $display("bitmap_extent_allocator_top_test NOT OK");
        end
        $finish;
    end

endmodule
